[hdl/isu_pkg.sv]
package isu_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 7;

  localparam logic KIND_UNION = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic [ValW-1:0] val_t;

  typedef struct packed {
    val_t lo;
    val_t hi;
  } range_t;

  // number of values shared by [s, e) and [lo, hi)
  function automatic val_t shared_values(val_t s, val_t e, val_t lo, val_t hi);
    val_t a;
    val_t b;
    a = (s > lo) ? s : lo;
    b = (e < hi) ? e : hi;
    return (b > a) ? (b - a) : '0;
  endfunction

endpackage

[hdl/isu_if.sv]
interface isu_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [isu_pkg::ValW-1:0]  range_start;
  logic [isu_pkg::ValW-1:0]  range_end;

  modport source (output valid, kind, range_start, range_end, input ready);
  modport sink   (input valid, kind, range_start, range_end, output ready);
endinterface

interface isu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [isu_pkg::ValW-1:0]   added_count;
  logic [isu_pkg::ValW-1:0]   covered_total;
  logic [isu_pkg::CountW-1:0] range_count;
  logic                       overflow;

  modport source (output valid, added_count, covered_total, range_count, overflow,
                  input ready);
  modport sink   (input valid, added_count, covered_total, range_count, overflow,
                  output ready);
endinterface

[hdl/isu_ram.sv]
module isu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/interval_set_union_engine.sv]
// Channel | Dir | Payload                                               | Handshake
// req     | in  | kind, range_start, range_end                          | valid/ready
// rsp     | out | added_count, covered_total, range_count, overflow     | valid/ready
//
// One request at a time. Clear and empty ranges go straight to DONE; a union runs
// a binary search of a non-empty table (SRCH_RD, SRCH_WT per step), then INS and
// SHIFT_WT for each entry shifted, ABS_RD and ABS_WT for each entry absorbed and
// COMP_WT for each entry moved down, all bounded by the table RAM's one read port.
// rst (synchronous) empties the set; table contents are not cleared.
// A new request is taken once the previous result sits in the output register,
// which holds while rsp.ready is low.
module interval_set_union_engine #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  isu_req_if.sink   req,
  isu_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [11:0] {
    IDLE     = 12'b000000000001,
    SRCH_RD  = 12'b000000000010,
    SRCH_WT  = 12'b000000000100,
    PROBE_RD = 12'b000000001000,
    PROBE_WT = 12'b000000010000,
    INS      = 12'b000000100000,
    SHIFT_WT = 12'b000001000000,
    ABS_RD   = 12'b000010000000,
    ABS_WT   = 12'b000100000000,
    MERGE_WR = 12'b001000000000,
    COMP_WT  = 12'b010000000000,
    DONE     = 12'b100000000000
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  isu_pkg::val_t          sum, sum_next;
  isu_pkg::val_t          s, e;
  logic [CW-1:0]          blo, blo_next, bhi, bhi_next;
  logic [CW-1:0]          idx, idx_next, ptr, ptr_next, wptr, wptr_next;
  isu_pkg::val_t          added, added_next;
  logic                   ovf, ovf_next;
  isu_pkg::val_t          new_lo, new_lo_next, cur_hi, cur_hi_next;
  logic [CW:0]            mid_sum;
  logic [CW-1:0]          mid;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  isu_pkg::range_t        ram_wdata, ram_rdata;

  logic                       out_valid;
  isu_pkg::val_t              out_added, out_total;
  logic [isu_pkg::CountW-1:0] out_count;
  logic                       out_ovf;

  isu_ram #(.WIDTH($bits(isu_pkg::range_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sum = {1'b0, blo} + {1'b0, bhi};
  assign mid     = mid_sum[CW:1];

  assign req.ready         = (state == IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.added_count   = out_added;
  assign rsp.covered_total = out_total;
  assign rsp.range_count   = out_count;
  assign rsp.overflow      = out_ovf;

  always_comb begin
    state_next  = state;
    count_next  = count;
    sum_next    = sum;
    blo_next    = blo;
    bhi_next    = bhi;
    idx_next    = idx;
    ptr_next    = ptr;
    wptr_next   = wptr;
    added_next  = added;
    ovf_next    = ovf;
    new_lo_next = new_lo;
    cur_hi_next = cur_hi;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    unique case (state)
      IDLE: begin
        added_next = '0;
        ovf_next   = 1'b0;
        blo_next   = '0;
        bhi_next   = count;
        if (req.valid) begin
          if (req.kind == isu_pkg::KIND_CLEAR) begin
            count_next = '0;
            sum_next   = '0;
            state_next = DONE;
          end else if (req.range_start >= req.range_end) begin
            state_next = DONE;
          end else if (count == '0) begin
            idx_next   = '0;
            ptr_next   = '0;
            state_next = INS;
          end else begin
            state_next = SRCH_RD;
          end
        end
      end

      SRCH_RD: begin
        ram_raddr  = mid[AW-1:0];
        state_next = SRCH_WT;
      end

      SRCH_WT: begin
        // first entry whose end reaches the start
        if (ram_rdata.hi < s) begin
          blo_next = mid + 1'b1;
        end else begin
          bhi_next = mid;
        end
        if (blo_next == bhi_next) begin
          idx_next = blo_next;
          if (blo_next == count) begin
            ptr_next   = count;
            state_next = INS;
          end else begin
            state_next = PROBE_RD;
          end
        end else begin
          state_next = SRCH_RD;
        end
      end

      PROBE_RD: begin
        ram_raddr  = idx[AW-1:0];
        state_next = PROBE_WT;
      end

      PROBE_WT: begin
        if (e < ram_rdata.lo) begin
          ptr_next   = count;
          state_next = INS;
        end else begin
          added_next  = (e - s) - isu_pkg::shared_values(s, e, ram_rdata.lo, ram_rdata.hi);
          new_lo_next = (s < ram_rdata.lo) ? s : ram_rdata.lo;
          cur_hi_next = (e > ram_rdata.hi) ? e : ram_rdata.hi;
          ptr_next    = idx + 1'b1;
          state_next  = ABS_RD;
        end
      end

      INS: begin
        if (count == CW'(TABLE_DEPTH)) begin
          ovf_next   = 1'b1;
          state_next = DONE;
        end else if (ptr == idx) begin
          ram_we     = 1'b1;
          ram_waddr  = idx[AW-1:0];
          ram_wdata  = '{lo: s, hi: e};
          count_next = count + 1'b1;
          added_next = e - s;
          sum_next   = sum + (e - s);
          state_next = DONE;
        end else begin
          ram_raddr  = AW'(ptr - 1'b1);
          state_next = SHIFT_WT;
        end
      end

      SHIFT_WT: begin
        // move entry up by one
        ram_we     = 1'b1;
        ram_waddr  = ptr[AW-1:0];
        ram_wdata  = ram_rdata;
        ptr_next   = ptr - 1'b1;
        state_next = INS;
      end

      ABS_RD: begin
        if (ptr < count) begin
          ram_raddr  = ptr[AW-1:0];
          state_next = ABS_WT;
        end else begin
          state_next = MERGE_WR;
        end
      end

      ABS_WT: begin
        if (ram_rdata.lo <= e) begin
          added_next  = added - isu_pkg::shared_values(s, e, ram_rdata.lo, ram_rdata.hi);
          cur_hi_next = (ram_rdata.hi > cur_hi) ? ram_rdata.hi : cur_hi;
          ptr_next    = ptr + 1'b1;
          state_next  = ABS_RD;
        end else begin
          state_next = MERGE_WR;
        end
      end

      MERGE_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        ram_wdata  = '{lo: new_lo, hi: cur_hi};
        wptr_next  = idx + 1'b1;
        sum_next   = sum + added;
        if (ptr < count) begin
          ram_raddr  = ptr[AW-1:0];
          state_next = COMP_WT;
        end else begin
          count_next = idx + 1'b1;
          state_next = DONE;
        end
      end

      COMP_WT: begin
        // close the gap left by absorbed entries
        ram_we    = 1'b1;
        ram_waddr = wptr[AW-1:0];
        ram_wdata = ram_rdata;
        wptr_next = wptr + 1'b1;
        ptr_next  = ptr + 1'b1;
        if (ptr_next < count) begin
          ram_raddr = ptr_next[AW-1:0];
        end else begin
          count_next = wptr_next;
          state_next = DONE;
        end
      end

      DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = IDLE;
        end
      end

      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      sum   <= sum_next;
      if (state == DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && req.valid) begin
      s <= req.range_start;
      e <= req.range_end;
    end
    blo    <= blo_next;
    bhi    <= bhi_next;
    idx    <= idx_next;
    ptr    <= ptr_next;
    wptr   <= wptr_next;
    added  <= added_next;
    ovf    <= ovf_next;
    new_lo <= new_lo_next;
    cur_hi <= cur_hi_next;
    if (state == DONE && (!out_valid || rsp.ready)) begin
      out_added <= added;
      out_total <= sum;
      out_count <= isu_pkg::CountW'(count);
      out_ovf   <= ovf;
    end
  end

endmodule

[tb/tb_interval_set_union_engine.sv]
`timescale 1ns / 100ps

module tb_interval_set_union_engine;

  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    isu_pkg::val_t              added;
    isu_pkg::val_t              total;
    logic [isu_pkg::CountW-1:0] count;
    logic                       ovf;
  } union_rsp_t;

  typedef struct packed {
    logic          kind;
    isu_pkg::val_t s;
    isu_pkg::val_t e;
    logic          known;
    union_rsp_t    rsp;
  } stim_row_t;

  logic clk;
  logic rst;

  isu_req_if req ();
  isu_rsp_if rsp ();

  interval_set_union_engine #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // predictor state
  isu_pkg::val_t set_lo [DEPTH];
  isu_pkg::val_t set_hi [DEPTH];
  int unsigned   set_n;
  isu_pkg::val_t set_sum;

  union_rsp_t expected_rsps[$];
  int         mismatches;
  int         src_idle_pct;
  int         snk_stall_pct;
  stim_row_t  directed[$];

  function automatic isu_pkg::val_t overlap(isu_pkg::val_t s, isu_pkg::val_t e,
                                            isu_pkg::val_t lo, isu_pkg::val_t hi);
    isu_pkg::val_t a;
    isu_pkg::val_t b;
    a = (s > lo) ? s : lo;
    b = (e < hi) ? e : hi;
    return (b > a) ? b - a : '0;
  endfunction

  function automatic union_rsp_t predict_union(logic kind, isu_pkg::val_t s,
                                               isu_pkg::val_t e);
    union_rsp_t r;
    int unsigned i;
    int unsigned j;
    int unsigned w;
    isu_pkg::val_t added;
    logic ovf;
    added = '0;
    ovf = 1'b0;
    if (kind == isu_pkg::KIND_CLEAR) begin
      set_n = 0;
      set_sum = '0;
    end else if (s < e) begin
      i = 0;
      while (i < set_n && set_hi[i] < s) i++;
      if (i >= set_n || e < set_lo[i]) begin
        if (set_n >= DEPTH) begin
          ovf = 1'b1;
        end else begin
          for (int k = set_n; k > i; k--) begin
            set_lo[k] = set_lo[k-1];
            set_hi[k] = set_hi[k-1];
          end
          set_lo[i] = s;
          set_hi[i] = e;
          set_n++;
          added = e - s;
        end
      end else begin
        added = (e - s) - overlap(s, e, set_lo[i], set_hi[i]);
        if (s < set_lo[i]) set_lo[i] = s;
        if (e > set_hi[i]) set_hi[i] = e;
        j = i + 1;
        while (j < set_n && set_lo[j] <= e) begin
          added -= overlap(s, e, set_lo[j], set_hi[j]);
          if (set_hi[j] > set_hi[i]) set_hi[i] = set_hi[j];
          j++;
        end
        w = i + 1;
        while (j < set_n) begin
          set_lo[w] = set_lo[j];
          set_hi[w] = set_hi[j];
          w++;
          j++;
        end
        set_n = w;
      end
      set_sum += added;
    end
    r.added = added;
    r.total = set_sum;
    r.count = set_n[isu_pkg::CountW-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: stall, check against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response at %0t", $time);
        end else begin
          union_rsp_t x;
          union_rsp_t a;
          x = expected_rsps.pop_front();
          a = '{rsp.added_count, rsp.covered_total, rsp.range_count, rsp.overflow};
          if (a !== x) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp added=%0d total=%0d count=%0d ovf=%0b, %s %0d %0d %0d %0b",
                       x.added, x.total, x.count, x.ovf, "got",
                       a.added, a.total, a.count, a.ovf);
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_request(logic kind, isu_pkg::val_t s, isu_pkg::val_t e,
                              logic known, union_rsp_t typed);
    union_rsp_t p;
    if ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.range_start <= s;
    req.range_end <= e;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = predict_union(kind, s, e);
    expected_rsps.push_back(known ? typed : p);
  endtask

  task automatic add_row(logic kind, isu_pkg::val_t s, isu_pkg::val_t e,
                         logic known, isu_pkg::val_t ad, isu_pkg::val_t tot,
                         logic [isu_pkg::CountW-1:0] cnt, logic ovf);
    directed.push_back('{kind, s, e, known, '{ad, tot, cnt, ovf}});
  endtask

  initial begin
    isu_pkg::val_t s;
    isu_pkg::val_t e;
    isu_pkg::val_t base;
    int unsigned pick;
    int timeout;
    mismatches = 0;
    set_n = 0;
    set_sum = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.kind = isu_pkg::KIND_UNION;
    req.range_start = '0;
    req.range_end = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_row(isu_pkg::KIND_UNION, 32'd5, 32'd5, 1'b1, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd9, 32'd3, 1'b1, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd10, 32'd20, 1'b1, 32'd10, 32'd10, 7'd1, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd20, 32'd30, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd0, 32'd10, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd50, 32'd60, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd40, 32'd45, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd15, 32'd55, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'hFFFFFFF0, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0, 7'd0, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
            7'd1, 1'b0);
    add_row(isu_pkg::KIND_UNION, 32'd7, 32'd8, 1'b1, 32'd0, 32'hFFFFFFFF, 7'd1, 1'b0);
    add_row(isu_pkg::KIND_CLEAR, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 7'd0, 1'b0);
    foreach (directed[k])
      send_request(directed[k].kind, directed[k].s, directed[k].e, directed[k].known,
                   directed[k].rsp);

    // fill the table with disjoint ranges, then hit overflow
    for (int k = 0; k < DEPTH + 2; k++)
      send_request(isu_pkg::KIND_UNION, k * 4, k * 4 + 2, 1'b0, '0);
    send_request(isu_pkg::KIND_UNION, 32'd1, 32'd2, 1'b0, '0);
    send_request(isu_pkg::KIND_UNION, 32'd3, 32'd4, 1'b0, '0);
    send_request(isu_pkg::KIND_CLEAR, 32'd0, 32'd0, 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
        default: begin src_idle_pct = 18; snk_stall_pct = 18; end
      endcase
      for (int k = 0; k < 240; k++) begin
        pick = $urandom_range(99);
        base = (pick < 10) ? $urandom : $urandom_range(2000);
        s = base;
        e = s + $urandom_range(40);
        if (pick < 3) begin
          send_request(isu_pkg::KIND_CLEAR, $urandom, $urandom, 1'b0, '0);
        end else if (pick < 8) begin
          send_request(isu_pkg::KIND_UNION, $urandom, $urandom, 1'b0, '0);
        end else if (pick < 12) begin
          // starts on a multiple of four and odd ends; empty when the end is below the start
          s = $urandom_range(999) << 2;
          e = ($urandom_range(999) << 2) | 32'd1;
          send_request(isu_pkg::KIND_UNION, s, e, 1'b0, '0);
        end else begin
          send_request(isu_pkg::KIND_UNION, s, (e < s) ? 32'hFFFFFFFF : e, 1'b0, '0);
        end
      end
    end
    req.valid <= 1'b0;

    timeout = 0;
    while (expected_rsps.size() != 0 && timeout < 200000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (50) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $display("== FAIL ==");
    end else if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/isu_pkg.sv
hdl/isu_if.sv
hdl/isu_ram.sv
hdl/interval_set_union_engine.sv
tb/tb_interval_set_union_engine.sv
